### rtl/tsc_pkg.sv
// ----------------------------------------------------------------------------
// tsc_pkg: token scanner shared definitions
// Token kinds, error codes, scan modes, keyword table and byte classes.
// ----------------------------------------------------------------------------
package tsc_pkg;

  localparam int KEYWORD_CHARS_DEF = 8;
  localparam int LINE_BITS_DEF     = 20;
  localparam int COLUMN_BITS_DEF   = 16;
  localparam int OFFSET_BITS_DEF   = 24;
  localparam int NUM_KEYWORDS      = 29;
  localparam int MAX_TOKENS        = 4;

  typedef logic [6:0] kind_t;
  typedef logic [1:0] err_t;

  localparam kind_t K_INC = 7'd29, K_ADD_EQ = 7'd30, K_ADD = 7'd31, K_DEC = 7'd32;
  localparam kind_t K_ARROW = 7'd33, K_SUB_EQ = 7'd34, K_SUB = 7'd35, K_MUL_EQ = 7'd36;
  localparam kind_t K_MUL = 7'd37, K_DIV_EQ = 7'd38, K_DIV = 7'd39, K_MOD_EQ = 7'd40;
  localparam kind_t K_MOD = 7'd41, K_EQ = 7'd42, K_ASSIGN = 7'd43, K_NE = 7'd44;
  localparam kind_t K_NOT = 7'd45, K_SHL_EQ = 7'd46, K_SHL = 7'd47, K_LE = 7'd48;
  localparam kind_t K_LT = 7'd49, K_SHR_EQ = 7'd50, K_SHR = 7'd51, K_GE = 7'd52;
  localparam kind_t K_GT = 7'd53, K_LAND = 7'd54, K_AND_EQ = 7'd55, K_AND = 7'd56;
  localparam kind_t K_LOR = 7'd57, K_OR_EQ = 7'd58, K_OR = 7'd59, K_XOR_EQ = 7'd60;
  localparam kind_t K_XOR = 7'd61, K_TILDE = 7'd62, K_QUEST = 7'd63, K_COLON = 7'd64;
  localparam kind_t K_DOT = 7'd65, K_LPAREN = 7'd66, K_RPAREN = 7'd67;
  localparam kind_t K_LBRACE = 7'd68, K_RBRACE = 7'd69, K_LBRACK = 7'd70;
  localparam kind_t K_RBRACK = 7'd71, K_SEMI = 7'd72, K_COMMA = 7'd73;
  localparam kind_t K_IDENT = 7'd74, K_NUM = 7'd75, K_STR = 7'd76, K_CHR = 7'd77;
  localparam kind_t K_EOF = 7'd78, K_ERR = 7'd79, K_NONE = 7'd127;

  localparam err_t E_NONE = 2'd0, E_OPEN_STR = 2'd1, E_OPEN_CHR = 2'd2, E_BAD = 2'd3;

  typedef enum logic [12:0] {
    M_IDLE     = 13'b0000000000001,
    M_IDENT    = 13'b0000000000010,
    M_NUM      = 13'b0000000000100,
    M_NUMDOT   = 13'b0000000001000,
    M_FRAC     = 13'b0000000010000,
    M_STR      = 13'b0000000100000,
    M_CHR      = 13'b0000001000000,
    M_LINESKIP = 13'b0000010000000,
    M_SLASH    = 13'b0000100000000,
    M_BLOCK    = 13'b0001000000000,
    M_OP1      = 13'b0010000000000,
    M_OP2      = 13'b0100000000000,
    M_DROP     = 13'b1000000000000
  } mode_t;

  // right-justified text, first char in the highest used byte
  localparam logic [63:0] KW_TEXT [NUM_KEYWORDS] = '{
    "int", "char", "float", "double", "void", "if", "else", "while", "for",
    "do", "return", "break", "continue", "struct", "union", "typedef",
    "sizeof", "const", "static", "extern", "switch", "case", "default",
    "enum", "goto", "signed", "unsigned", "long", "short"};
  localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{
    4'd3, 4'd4, 4'd5, 4'd6, 4'd4, 4'd2, 4'd4, 4'd5, 4'd3, 4'd2, 4'd6, 4'd5, 4'd8,
    4'd6, 4'd5, 4'd7, 4'd6, 4'd5, 4'd6, 4'd6, 4'd6, 4'd4, 4'd7, 4'd4, 4'd4, 4'd6,
    4'd8, 4'd4, 4'd5};

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic logic is_numeral(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return b == " " || b == 8'h09 || b == 8'h0D || b == 8'h0A;
  endfunction

  function automatic logic op_lead(input logic [7:0] c);
    return c == "+" || c == "-" || c == "*" || c == "%" || c == "=" || c == "!" ||
           c == "<" || c == ">" || c == "&" || c == "|" || c == "^";
  endfunction

  function automatic kind_t op_single(input logic [7:0] c);
    kind_t k;
    case (c)
      "+": k = K_ADD;    "-": k = K_SUB;    "*": k = K_MUL;    "/": k = K_DIV;
      "%": k = K_MOD;    "=": k = K_ASSIGN; "!": k = K_NOT;    "<": k = K_LT;
      ">": k = K_GT;     "&": k = K_AND;    "|": k = K_OR;     "^": k = K_XOR;
      "~": k = K_TILDE;  "?": k = K_QUEST;  ":": k = K_COLON;  ".": k = K_DOT;
      "(": k = K_LPAREN; ")": k = K_RPAREN; "{": k = K_LBRACE; "}": k = K_RBRACE;
      "[": k = K_LBRACK; "]": k = K_RBRACK; ";": k = K_SEMI;   ",": k = K_COMMA;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic kind_t op_pair(input logic [7:0] p, input logic [7:0] b);
    kind_t k;
    case (p)
      "+": k = (b == "+") ? K_INC : (b == "=") ? K_ADD_EQ : K_NONE;
      "-": k = (b == "-") ? K_DEC : (b == ">") ? K_ARROW : (b == "=") ? K_SUB_EQ : K_NONE;
      "*": k = (b == "=") ? K_MUL_EQ : K_NONE;
      "%": k = (b == "=") ? K_MOD_EQ : K_NONE;
      "=": k = (b == "=") ? K_EQ : K_NONE;
      "!": k = (b == "=") ? K_NE : K_NONE;
      "<": k = (b == "=") ? K_LE : K_NONE;
      ">": k = (b == "=") ? K_GE : K_NONE;
      "&": k = (b == "&") ? K_LAND : (b == "=") ? K_AND_EQ : K_NONE;
      "|": k = (b == "|") ? K_LOR : (b == "=") ? K_OR_EQ : K_NONE;
      "^": k = (b == "=") ? K_XOR_EQ : K_NONE;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

endpackage

### rtl/tsc_if.sv
// ----------------------------------------------------------------------------
// tsc_if: token scanner channels
// Byte input channel and token result channel, valid/ready.
// ----------------------------------------------------------------------------
interface tsc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] src_byte;
  logic       end_of_source;
  modport source (output valid, src_byte, end_of_source, input ready);
  modport sink (input valid, src_byte, end_of_source, output ready);
endinterface

interface tsc_tok_if #(
  parameter int LINE_BITS   = tsc_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = tsc_pkg::COLUMN_BITS_DEF,
  parameter int OFFSET_BITS = tsc_pkg::OFFSET_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [6:0]             token_kind;
  logic [1:0]             error_code;
  logic [7:0]             bad_byte;
  logic [LINE_BITS-1:0]   line_number;
  logic [COLUMN_BITS-1:0] first_column;
  logic [OFFSET_BITS-1:0] start_offset;
  logic [15:0]            token_length;
  logic                   last_result;
  modport source (output valid, token_kind, error_code, bad_byte, line_number,
                  first_column, start_offset, token_length, last_result, input ready);
  modport sink (input valid, token_kind, error_code, bad_byte, line_number,
                first_column, start_offset, token_length, last_result, output ready);
endinterface

### rtl/c_subset_token_scanner.sv
// ----------------------------------------------------------------------------
// c_subset_token_scanner: streaming C subset lexer
// Scans one source byte per transfer and emits up to four tokens per byte.
// ----------------------------------------------------------------------------
// Tokens of a byte appear in the cycle after its transfer.
// Throughput: one byte per cycle while out_ch is ready; a byte with several
//   tokens holds the input while the token buffer drains one per cycle.
// Reset (rst_n low, synchronous): scanner idle, line 1, column 1, offset 0,
//   token buffer empty. The end-of-source byte also resets the scan state.
module c_subset_token_scanner #(
  parameter int KEYWORD_CHARS = tsc_pkg::KEYWORD_CHARS_DEF,
  parameter int LINE_BITS     = tsc_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS   = tsc_pkg::COLUMN_BITS_DEF,
  parameter int OFFSET_BITS   = tsc_pkg::OFFSET_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  tsc_byte_if.sink  in_ch,
  tsc_tok_if.source out_ch
);
  import tsc_pkg::*;

  localparam int KWI = $clog2(KEYWORD_CHARS);
  localparam int CSW = ((COLUMN_BITS > 16) ? COLUMN_BITS : 16) + 1;
  localparam int OSW = OFFSET_BITS + 1;

  typedef struct packed {
    mode_t                               mode;
    logic [7:0]                          pend;
    logic [KEYWORD_CHARS-1:0][7:0]       kw;
    logic [15:0]                         len;
    logic [LINE_BITS-1:0]                line;
    logic [COLUMN_BITS-1:0]              col;
    logic [COLUMN_BITS-1:0]              tcol;
    logic [OFFSET_BITS-1:0]              off;
    logic [OFFSET_BITS-1:0]              toff;
    logic                                esc;
  } st_t;

  typedef struct packed {
    kind_t                  kind;
    err_t                   err;
    logic [7:0]             bad;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] col;
    logic [OFFSET_BITS-1:0] off;
    logic [15:0]            len;
    logic                   last;
  } tok_t;

  typedef tok_t [MAX_TOKENS-1:0] tbuf_t;

  function automatic st_t st_reset();
    st_t s;
    s      = '0;
    s.mode = M_IDLE;
    s.line = LINE_BITS'(1);
    s.col  = COLUMN_BITS'(1);
    s.tcol = COLUMN_BITS'(1);
    return s;
  endfunction

  function automatic logic [15:0] len_sat(input logic [15:0] a, input logic [1:0] n);
    logic [16:0] sm;
    sm = {1'b0, a} + 17'(n);
    return sm[16] ? 16'hFFFF : sm[15:0];
  endfunction

  function automatic void consume(inout st_t s, input logic [7:0] b);
    if (s.off != '1) s.off = s.off + OFFSET_BITS'(1);
    if (b == 8'h0A) begin
      if (s.line != '1) s.line = s.line + LINE_BITS'(1);
      s.col = COLUMN_BITS'(1);
    end else if (s.col != '1) begin
      s.col = s.col + COLUMN_BITS'(1);
    end
  endfunction

  function automatic void emit(inout tbuf_t r, inout logic [2:0] n, input st_t s,
                               input kind_t k, input err_t e, input logic [7:0] bad,
                               input logic [COLUMN_BITS-1:0] col,
                               input logic [OFFSET_BITS-1:0] off, input logic [15:0] len);
    tok_t t;
    t.kind = k; t.err = e; t.bad = bad; t.line = s.line;
    t.col = col; t.off = off; t.len = len; t.last = 1'b0;
    if (n < 3'(MAX_TOKENS)) begin
      r[n[1:0]] = t;
      n = n + 3'd1;
    end
  endfunction

  function automatic void emit_tok(inout tbuf_t r, inout logic [2:0] n, input st_t s,
                                   input kind_t k, input err_t e, input logic [7:0] bad);
    emit(r, n, s, k, e, bad, s.tcol, s.toff, s.len);
  endfunction

  function automatic void emit_num_dot(inout tbuf_t r, inout logic [2:0] n, input st_t s);
    logic [CSW-1:0] cs;
    logic [OSW-1:0] os;
    logic [COLUMN_BITS-1:0] dc;
    logic [OFFSET_BITS-1:0] dof;
    cs  = CSW'(s.tcol) + CSW'(s.len);
    os  = OSW'(s.toff) + OSW'(s.len);
    dc  = (cs > CSW'({COLUMN_BITS{1'b1}})) ? '1 : cs[COLUMN_BITS-1:0];
    dof = os[OFFSET_BITS] ? '1 : os[OFFSET_BITS-1:0];
    emit_tok(r, n, s, K_NUM, E_NONE, 8'h00);
    emit(r, n, s, K_DOT, E_NONE, 8'h00, dc, dof, 16'd1);
  endfunction

  function automatic kind_t ident_kind(input st_t s);
    kind_t k;
    logic  m;
    int    l;
    k = K_IDENT;
    if (s.len <= 16'(KEYWORD_CHARS)) begin
      for (int i = NUM_KEYWORDS - 1; i >= 0; i--) begin
        l = int'(KW_LEN[i]);
        m = (s.len == 16'(l));
        for (int j = 0; j < 8; j++) begin
          if (j < l && s.kw[KWI'(j)] != KW_TEXT[i][(l-1-j)*8 +: 8]) m = 1'b0;
        end
        if (m) k = 7'(i);
      end
    end
    return k;
  endfunction

  function automatic logic handle(inout st_t s, inout tbuf_t r, inout logic [2:0] n,
                                  input logic [7:0] b);
    logic  redo;
    kind_t k;
    redo = 1'b0;
    case (s.mode)
      M_IDLE: begin
        if (is_blank(b)) begin
          consume(s, b);
        end else if (b == "#") begin
          s.mode = M_LINESKIP;
          consume(s, b);
        end else begin
          s.tcol = s.col; s.toff = s.off; s.len = 16'd1; s.esc = 1'b0;
          consume(s, b);
          if (is_alpha(b)) begin
            s.kw[0] = b; s.mode = M_IDENT;
          end else if (is_numeral(b)) s.mode = M_NUM;
          else if (b == "\"") s.mode = M_STR;
          else if (b == "'") s.mode = M_CHR;
          else if (b == "/") s.mode = M_SLASH;
          else if (op_lead(b)) begin
            s.pend = b; s.mode = M_OP1;
          end else begin
            k = op_single(b);
            if (k != K_NONE) emit_tok(r, n, s, k, E_NONE, 8'h00);
            else begin
              emit_tok(r, n, s, K_ERR, E_BAD, b);
              s.mode = M_DROP;
            end
          end
        end
      end
      M_IDENT: begin
        if (is_alpha(b) || is_numeral(b)) begin
          if (s.len < 16'(KEYWORD_CHARS)) s.kw[s.len[KWI-1:0]] = b;
          s.len = len_sat(s.len, 2'd1);
          consume(s, b);
        end else begin
          emit_tok(r, n, s, ident_kind(s), E_NONE, 8'h00);
          s.mode = M_IDLE; redo = 1'b1;
        end
      end
      M_NUM: begin
        if (is_numeral(b)) begin
          s.len = len_sat(s.len, 2'd1); consume(s, b);
        end else if (b == ".") begin
          s.mode = M_NUMDOT; consume(s, b);
        end else begin
          emit_tok(r, n, s, K_NUM, E_NONE, 8'h00);
          s.mode = M_IDLE; redo = 1'b1;
        end
      end
      M_NUMDOT: begin
        if (is_numeral(b)) begin
          s.len = len_sat(s.len, 2'd2); s.mode = M_FRAC; consume(s, b);
        end else begin
          emit_num_dot(r, n, s);
          s.mode = M_IDLE; redo = 1'b1;
        end
      end
      M_FRAC: begin
        if (is_numeral(b)) begin
          s.len = len_sat(s.len, 2'd1); consume(s, b);
        end else begin
          emit_tok(r, n, s, K_NUM, E_NONE, 8'h00);
          s.mode = M_IDLE; redo = 1'b1;
        end
      end
      M_STR, M_CHR: begin
        consume(s, b);
        s.len = len_sat(s.len, 2'd1);
        if (s.esc) s.esc = 1'b0;
        else if (b == "\\") s.esc = 1'b1;
        else if (b == ((s.mode == M_STR) ? 8'h22 : 8'h27)) begin
          emit_tok(r, n, s, (s.mode == M_STR) ? K_STR : K_CHR, E_NONE, 8'h00);
          s.mode = M_IDLE;
        end
      end
      M_LINESKIP: begin
        if (b == 8'h0A) begin
          s.mode = M_IDLE; redo = 1'b1;
        end else consume(s, b);
      end
      M_SLASH: begin
        if (b == "/") begin
          s.mode = M_LINESKIP; consume(s, b);
        end else if (b == "*") begin
          s.mode = M_BLOCK; s.pend = 8'h00; consume(s, b);
        end else if (b == "=") begin
          consume(s, b); s.len = len_sat(s.len, 2'd1);
          emit_tok(r, n, s, K_DIV_EQ, E_NONE, 8'h00);
          s.mode = M_IDLE;
        end else begin
          emit_tok(r, n, s, K_DIV, E_NONE, 8'h00);
          s.mode = M_IDLE; redo = 1'b1;
        end
      end
      M_BLOCK: begin
        consume(s, b);
        if (s.pend == "*" && b == "/") begin
          s.mode = M_IDLE; s.pend = 8'h00;
        end else s.pend = b;
      end
      M_OP1: begin
        k = op_pair(s.pend, b);
        if ((s.pend == "<" || s.pend == ">") && b == s.pend) begin
          s.len = len_sat(s.len, 2'd1); consume(s, b); s.mode = M_OP2;
        end else if (k != K_NONE) begin
          s.len = len_sat(s.len, 2'd1); consume(s, b);
          emit_tok(r, n, s, k, E_NONE, 8'h00);
          s.mode = M_IDLE; s.pend = 8'h00;
        end else begin
          emit_tok(r, n, s, op_single(s.pend), E_NONE, 8'h00);
          s.mode = M_IDLE; s.pend = 8'h00; redo = 1'b1;
        end
      end
      M_OP2: begin
        if (b == "=") begin
          s.len = len_sat(s.len, 2'd1); consume(s, b);
          emit_tok(r, n, s, (s.pend == "<") ? K_SHL_EQ : K_SHR_EQ, E_NONE, 8'h00);
          s.mode = M_IDLE; s.pend = 8'h00;
        end else begin
          emit_tok(r, n, s, (s.pend == "<") ? K_SHL : K_SHR, E_NONE, 8'h00);
          s.mode = M_IDLE; s.pend = 8'h00; redo = 1'b1;
        end
      end
      default: consume(s, b);
    endcase
    return redo;
  endfunction

  function automatic void flush(inout tbuf_t r, inout logic [2:0] n, input st_t s);
    case (s.mode)
      M_IDENT:        emit_tok(r, n, s, ident_kind(s), E_NONE, 8'h00);
      M_NUM, M_FRAC:  emit_tok(r, n, s, K_NUM, E_NONE, 8'h00);
      M_NUMDOT:       emit_num_dot(r, n, s);
      M_STR:          emit_tok(r, n, s, K_ERR, E_OPEN_STR, 8'h00);
      M_CHR:          emit_tok(r, n, s, K_ERR, E_OPEN_CHR, 8'h00);
      M_SLASH:        emit_tok(r, n, s, K_DIV, E_NONE, 8'h00);
      M_OP1:          emit_tok(r, n, s, op_single(s.pend), E_NONE, 8'h00);
      M_OP2:          emit_tok(r, n, s, (s.pend == "<") ? K_SHL : K_SHR, E_NONE, 8'h00);
      default: ;
    endcase
  endfunction

  st_t        st_r, st_nxt;
  tbuf_t      res_r, res_nxt;
  logic [2:0] cnt_r, cnt_nxt, n_new;
  logic [1:0] idx_r, idx_nxt;
  logic       in_xfer, out_xfer;

  assign in_ch.ready = (cnt_r == 3'd0) || (cnt_r == 3'd1 && out_ch.ready);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_xfer    = out_ch.valid && out_ch.ready;

  always_comb begin
    st_t   s;
    tbuf_t r;
    logic [2:0] n;
    logic  go;
    s  = st_r;
    r  = '0;
    n  = 3'd0;
    go = 1'b1;
    for (int p = 0; p < 2; p++) begin
      if (go) go = handle(s, r, n, in_ch.src_byte);
    end
    if (in_ch.end_of_source) begin
      flush(r, n, s);
      emit(r, n, s, K_EOF, E_NONE, 8'h00, s.col, s.off, 16'd0);
      s = st_reset();
    end
    if (n != 3'd0) r[2'(n - 3'd1)].last = 1'b1;
    n_new   = n;
    res_nxt = r;
    st_nxt  = in_xfer ? s : st_r;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (out_xfer) begin
      cnt_nxt = cnt_r - 3'd1;
      idx_nxt = idx_r + 2'd1;
    end
    if (in_xfer) begin
      cnt_nxt = n_new;
      idx_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= st_reset();
      cnt_r <= 3'd0;
      idx_r <= 2'd0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) res_r <= res_nxt;
  end

  assign out_ch.valid        = (cnt_r != 3'd0);
  assign out_ch.token_kind   = res_r[idx_r].kind;
  assign out_ch.error_code   = res_r[idx_r].err;
  assign out_ch.bad_byte     = res_r[idx_r].bad;
  assign out_ch.line_number  = res_r[idx_r].line;
  assign out_ch.first_column = res_r[idx_r].col;
  assign out_ch.start_offset = res_r[idx_r].off;
  assign out_ch.token_length = res_r[idx_r].len;
  assign out_ch.last_result  = res_r[idx_r].last;

endmodule

### bench/c_subset_token_scanner_test.sv
// ----------------------------------------------------------------------------
// c_subset_token_scanner_test: token scanner testbench
// Streams C-like source bytes into the scanner and checks each token against
// a local scanner model. A short table covers keywords, operators, literals,
// comments, error tokens and end-of-source flushes. Random C-like fragments
// with noise bytes follow. The channels stall at random but for three rows.
// ----------------------------------------------------------------------------
module c_subset_token_scanner_test;
  import tsc_pkg::*;

  localparam int unsigned LINE_TOP = (1 << LINE_BITS_DEF) - 1;
  localparam int unsigned COL_TOP  = (1 << COLUMN_BITS_DEF) - 1;
  localparam int unsigned OFF_TOP  = (1 << OFFSET_BITS_DEF) - 1;
  localparam int unsigned LEN_TOP  = 65535;
  localparam int          STALL_LIMIT = 1000;
  localparam int          RANDOM_BYTES = 40;

  typedef struct {
    kind_t       kind;
    err_t        err;
    logic [7:0]  bad;
    logic [19:0] line;
    logic [15:0] col;
    logic [23:0] off;
    logic [15:0] len;
    logic        last;
  } token_t;

  typedef struct {
    logic [8:0] raw;
    string      text;
    bit         eos;
    bit         typed;
    kind_t      kind;
    err_t       err;
    logic [7:0] bad;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   stall_on = 1'b1;

  tsc_byte_if in_ch ();
  tsc_tok_if  out_ch ();

  c_subset_token_scanner dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  string kw_names [29] = '{
    "int", "char", "float", "double", "void", "if", "else", "while", "for",
    "do", "return", "break", "continue", "struct", "union", "typedef",
    "sizeof", "const", "static", "extern", "switch", "case", "default",
    "enum", "goto", "signed", "unsigned", "long", "short"};

  string op_names [45] = '{
    "++", "+=", "+", "--", "->", "-=", "-", "*=", "*", "/=", "/", "%=", "%",
    "==", "=", "!=", "!", "<<=", "<<", "<=", "<", ">>=", ">>", ">=", ">",
    "&&", "&=", "&", "||", "|=", "|", "^=", "^", "~", "?", ":", ".", "(",
    ")", "{", "}", "[", "]", ";", ","};

  // scanner model state
  mode_t       sc_mode;
  logic [7:0]  sc_pend;
  logic [7:0]  sc_kw [8];
  int unsigned sc_len, sc_line, sc_col, sc_tcol, sc_off, sc_toff;
  bit          sc_esc;

  token_t byte_tokens [$];
  token_t expected_tokens [$];

  int bytes_sent, tokens_seen, mismatches, quiet_cycles;

  function automatic int unsigned sat(int unsigned a, int unsigned b, int unsigned top);
    longint unsigned s;
    s = longint'(a) + longint'(b);
    return (s > top) ? top : int'(s);
  endfunction

  function automatic void scanner_clear();
    sc_mode = M_IDLE;
    sc_pend = 8'd0;
    foreach (sc_kw[i]) sc_kw[i] = 8'd0;
    sc_len = 0;
    sc_line = 1;
    sc_col = 1;
    sc_tcol = 1;
    sc_off = 0;
    sc_toff = 0;
    sc_esc = 1'b0;
  endfunction

  function automatic void put(kind_t k, err_t e, logic [7:0] bd,
                              int unsigned c, int unsigned o, int unsigned l);
    token_t t;
    if (byte_tokens.size() >= MAX_TOKENS) return;
    t.kind = k;
    t.err  = e;
    t.bad  = bd;
    t.line = sc_line[19:0];
    t.col  = c[15:0];
    t.off  = o[23:0];
    t.len  = l[15:0];
    t.last = 1'b0;
    byte_tokens.push_back(t);
  endfunction

  function automatic void put_tok(kind_t k, err_t e, logic [7:0] bd);
    put(k, e, bd, sc_tcol, sc_toff, sc_len);
  endfunction

  function automatic void advance(logic [7:0] b);
    sc_off = sat(sc_off, 1, OFF_TOP);
    if (b == 8'h0A) begin
      sc_line = sat(sc_line, 1, LINE_TOP);
      sc_col = 1;
    end else begin
      sc_col = sat(sc_col, 1, COL_TOP);
    end
  endfunction

  function automatic bit letter(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic bit digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic kind_t op_one(logic [7:0] c);
    for (int i = 0; i < 45; i++)
      if (op_names[i].len() == 1 && op_names[i][0] == c) return kind_t'(29 + i);
    return K_NONE;
  endfunction

  function automatic kind_t op_two(logic [7:0] p, logic [7:0] b);
    if (p == "<" || p == ">") begin
      if (b == "=") return (p == "<") ? K_LE : K_GE;
      return K_NONE;
    end
    for (int i = 0; i < 45; i++)
      if (op_names[i].len() == 2 && op_names[i][0] == p && op_names[i][1] == b)
        return kind_t'(29 + i);
    return K_NONE;
  endfunction

  function automatic kind_t word_kind();
    bit same;
    if (sc_len > 8) return K_IDENT;
    for (int i = 0; i < 29; i++) begin
      if (kw_names[i].len() == sc_len) begin
        same = 1'b1;
        for (int j = 0; j < sc_len; j++)
          if (sc_kw[j] != kw_names[i][j]) same = 1'b0;
        if (same) return kind_t'(i);
      end
    end
    return K_IDENT;
  endfunction

  function automatic void number_and_dot();
    put_tok(K_NUM, E_NONE, 8'd0);
    put(K_DOT, E_NONE, 8'd0, sat(sc_tcol, sc_len, COL_TOP), sat(sc_toff, sc_len, OFF_TOP), 1);
  endfunction

  // returns 1 when the byte must be scanned again from idle
  function automatic bit scan(logic [7:0] b);
    kind_t k;
    case (sc_mode)
      M_IDLE: begin
        if (b == " " || b == 8'h09 || b == 8'h0D || b == 8'h0A) begin
          advance(b);
          return 1'b0;
        end
        if (b == "#") begin
          sc_mode = M_LINESKIP;
          advance(b);
          return 1'b0;
        end
        sc_tcol = sc_col;
        sc_toff = sc_off;
        sc_len = 1;
        sc_esc = 1'b0;
        advance(b);
        if (letter(b)) begin
          sc_kw[0] = b;
          sc_mode = M_IDENT;
        end else if (digit(b)) sc_mode = M_NUM;
        else if (b == "\"") sc_mode = M_STR;
        else if (b == "'") sc_mode = M_CHR;
        else if (b == "/") sc_mode = M_SLASH;
        else if (op_two(b, "=") != K_NONE) begin
          sc_pend = b;
          sc_mode = M_OP1;
        end else begin
          k = op_one(b);
          if (k != K_NONE) put_tok(k, E_NONE, 8'd0);
          else begin
            put_tok(K_ERR, E_BAD, b);
            sc_mode = M_DROP;
          end
        end
        return 1'b0;
      end
      M_IDENT: begin
        if (letter(b) || digit(b)) begin
          if (sc_len < 8) sc_kw[sc_len] = b;
          sc_len = sat(sc_len, 1, LEN_TOP);
          advance(b);
          return 1'b0;
        end
        put_tok(word_kind(), E_NONE, 8'd0);
        sc_mode = M_IDLE;
        return 1'b1;
      end
      M_NUM: begin
        if (digit(b)) begin
          sc_len = sat(sc_len, 1, LEN_TOP);
          advance(b);
          return 1'b0;
        end
        if (b == ".") begin
          sc_mode = M_NUMDOT;
          advance(b);
          return 1'b0;
        end
        put_tok(K_NUM, E_NONE, 8'd0);
        sc_mode = M_IDLE;
        return 1'b1;
      end
      M_NUMDOT: begin
        if (digit(b)) begin
          sc_len = sat(sc_len, 2, LEN_TOP);
          sc_mode = M_FRAC;
          advance(b);
          return 1'b0;
        end
        number_and_dot();
        sc_mode = M_IDLE;
        return 1'b1;
      end
      M_FRAC: begin
        if (digit(b)) begin
          sc_len = sat(sc_len, 1, LEN_TOP);
          advance(b);
          return 1'b0;
        end
        put_tok(K_NUM, E_NONE, 8'd0);
        sc_mode = M_IDLE;
        return 1'b1;
      end
      M_STR, M_CHR: begin
        advance(b);
        sc_len = sat(sc_len, 1, LEN_TOP);
        if (sc_esc) sc_esc = 1'b0;
        else if (b == "\\") sc_esc = 1'b1;
        else if (b == ((sc_mode == M_STR) ? "\"" : "'")) begin
          put_tok((sc_mode == M_STR) ? K_STR : K_CHR, E_NONE, 8'd0);
          sc_mode = M_IDLE;
        end
        return 1'b0;
      end
      M_LINESKIP: begin
        if (b == 8'h0A) begin
          sc_mode = M_IDLE;
          return 1'b1;
        end
        advance(b);
        return 1'b0;
      end
      M_SLASH: begin
        if (b == "/") begin
          sc_mode = M_LINESKIP;
          advance(b);
          return 1'b0;
        end
        if (b == "*") begin
          sc_mode = M_BLOCK;
          sc_pend = 8'd0;
          advance(b);
          return 1'b0;
        end
        if (b == "=") begin
          advance(b);
          sc_len = sat(sc_len, 1, LEN_TOP);
          put_tok(K_DIV_EQ, E_NONE, 8'd0);
          sc_mode = M_IDLE;
          return 1'b0;
        end
        put_tok(K_DIV, E_NONE, 8'd0);
        sc_mode = M_IDLE;
        return 1'b1;
      end
      M_BLOCK: begin
        advance(b);
        if (sc_pend == "*" && b == "/") begin
          sc_mode = M_IDLE;
          sc_pend = 8'd0;
        end else sc_pend = b;
        return 1'b0;
      end
      M_OP1: begin
        if ((sc_pend == "<" || sc_pend == ">") && b == sc_pend) begin
          sc_len = sat(sc_len, 1, LEN_TOP);
          advance(b);
          sc_mode = M_OP2;
          return 1'b0;
        end
        k = op_two(sc_pend, b);
        if (k != K_NONE) begin
          sc_len = sat(sc_len, 1, LEN_TOP);
          advance(b);
          put_tok(k, E_NONE, 8'd0);
          sc_mode = M_IDLE;
          sc_pend = 8'd0;
          return 1'b0;
        end
        put_tok(op_one(sc_pend), E_NONE, 8'd0);
        sc_mode = M_IDLE;
        sc_pend = 8'd0;
        return 1'b1;
      end
      M_OP2: begin
        if (b == "=") begin
          sc_len = sat(sc_len, 1, LEN_TOP);
          advance(b);
          put_tok((sc_pend == "<") ? K_SHL_EQ : K_SHR_EQ, E_NONE, 8'd0);
          sc_mode = M_IDLE;
          sc_pend = 8'd0;
          return 1'b0;
        end
        put_tok((sc_pend == "<") ? K_SHL : K_SHR, E_NONE, 8'd0);
        sc_mode = M_IDLE;
        sc_pend = 8'd0;
        return 1'b1;
      end
      default: begin
        advance(b);
        return 1'b0;
      end
    endcase
  endfunction

  function automatic void scanner_flush();
    case (sc_mode)
      M_IDENT:        put_tok(word_kind(), E_NONE, 8'd0);
      M_NUM, M_FRAC:  put_tok(K_NUM, E_NONE, 8'd0);
      M_NUMDOT:       number_and_dot();
      M_STR:          put_tok(K_ERR, E_OPEN_STR, 8'd0);
      M_CHR:          put_tok(K_ERR, E_OPEN_CHR, 8'd0);
      M_SLASH:        put_tok(K_DIV, E_NONE, 8'd0);
      M_OP1:          put_tok(op_one(sc_pend), E_NONE, 8'd0);
      M_OP2:          put_tok((sc_pend == "<") ? K_SHL : K_SHR, E_NONE, 8'd0);
      default: ;
    endcase
  endfunction

  function automatic void scan_byte(logic [7:0] b, bit eos, bit typed, kind_t k,
                                    err_t e, logic [7:0] bd);
    byte_tokens.delete();
    for (int pass = 0; pass < 3; pass++)
      if (!scan(b)) break;
    if (eos) begin
      scanner_flush();
      put(K_EOF, E_NONE, 8'd0, sc_col, sc_off, 0);
      scanner_clear();
    end
    if (byte_tokens.size() > 0) begin
      byte_tokens[byte_tokens.size() - 1].last = 1'b1;
      if (typed) begin
        byte_tokens[0].kind = k;
        byte_tokens[0].err = e;
        byte_tokens[0].bad = bd;
      end
    end
    foreach (byte_tokens[i]) expected_tokens.push_back(byte_tokens[i]);
  endfunction

  task automatic send(logic [7:0] b, bit eos, bit typed, kind_t k, err_t e,
                      logic [7:0] bd);
    while (stall_on && $urandom_range(99) < 28) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.src_byte <= b;
    in_ch.end_of_source <= eos;
    do @(posedge clk); while (!in_ch.ready);
    scan_byte(b, eos, typed, k, e, bd);
    bytes_sent++;
  endtask

  task automatic send_plain(logic [8:0] item);
    send(item[7:0], item[8], 1'b0, K_NONE, E_NONE, 8'd0);
  endtask

  function automatic string random_word(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: s = {s, string'(byte'($urandom_range("a", "z")))};
        1: s = {s, string'(byte'($urandom_range("A", "Z")))};
        2: s = {s, (i == 0) ? "_" : string'(byte'($urandom_range("0", "9")))};
        default: s = {s, string'(byte'($urandom_range("a", "z")))};
      endcase
    end
    return s;
  endfunction

  function automatic string random_text(int n, logic [7:0] quote);
    string s;
    byte   c;
    s = "";
    for (int i = 0; i < n; i++) begin
      c = byte'($urandom_range(32, 126));
      if (c == quote) c = "x";
      if (c == "\\") s = {s, "\\", string'(byte'($urandom_range(32, 126)))};
      else s = {s, string'(c)};
    end
    return s;
  endfunction

  function automatic string random_digits(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(byte'($urandom_range("0", "9")))};
    return s;
  endfunction

  row_t rows [] = '{
    '{9'h180, "x ",              1'b1, 1'b0, K_NONE,  E_NONE,     8'h00},
    '{9'h100, "",                1'b1, 1'b1, K_ERR,   E_BAD,      8'h00},
    '{9'h1FF, "",                1'b1, 1'b1, K_ERR,   E_BAD,      8'hFF},
    '{9'h000, "continue ",       1'b0, 1'b1, 7'd12,   E_NONE,     8'h00},
    '{9'h000, "unsigned;",       1'b0, 1'b1, 7'd26,   E_NONE,     8'h00},
    '{9'h000, "unsignedx abcdefghij ", 1'b0, 1'b1, K_IDENT, E_NONE, 8'h00},
    '{9'h000, "a<<=",            1'b0, 1'b1, K_SHL_EQ, E_NONE,    8'h00},
    '{9'h000, " >>=",            1'b0, 1'b1, K_SHR_EQ, E_NONE,    8'h00},
    '{9'h000, "->",              1'b0, 1'b1, K_ARROW, E_NONE,     8'h00},
    '{9'h000, "12.x",            1'b0, 1'b1, K_NUM,   E_NONE,     8'h00},
    '{9'h000, " 3.14 \"a\\\"b\"", 1'b0, 1'b1, K_STR,  E_NONE,     8'h00},
    '{9'h000, "'\\''",           1'b0, 1'b1, K_CHR,   E_NONE,     8'h00},
    '{9'h000, "#define x 1\n// c\n/* * / */ /=", 1'b0, 1'b1, K_DIV_EQ, E_NONE, 8'h00},
    '{9'h000, "x \"ab",          1'b1, 1'b1, K_ERR,   E_OPEN_STR, 8'h00},
    '{9'h000, "'a",              1'b1, 1'b1, K_ERR,   E_OPEN_CHR, 8'h00},
    '{9'h000, "/*/ 7",           1'b1, 1'b1, K_EOF,   E_NONE,     8'h00},
    '{9'h000, "5.",              1'b1, 1'b1, K_NUM,   E_NONE,     8'h00},
    '{9'h000, "a<",              1'b1, 1'b0, K_NONE,  E_NONE,     8'h00},
    '{9'h000, "++ += -- -= *= * %= % == = != ! <= < >= > >> << && &= & || |= | ^= ^",
      1'b0, 1'b0, K_NONE, E_NONE, 8'h00},
    '{9'h000, " ~ ? : ( ) { } [ ] ; , / - + .", 1'b1, 1'b0, K_NONE, E_NONE, 8'h00},
    '{9'h000, "int char float double void if else while for do return break ",
      1'b0, 1'b0, K_NONE, E_NONE, 8'h00},
    '{9'h000, "struct union typedef sizeof const static extern switch case ",
      1'b0, 1'b0, K_NONE, E_NONE, 8'h00},
    '{9'h000, "default enum goto signed long short\tq\r\n", 1'b1, 1'b0, K_NONE,
      E_NONE, 8'h00}};

  logic [8:0] source_q [$];

  initial begin
    string frag;
    int    n;
    in_ch.valid <= 1'b0;
    in_ch.src_byte <= 8'd0;
    in_ch.end_of_source <= 1'b0;
    scanner_clear();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[r]) begin
      // operator rows and the first keyword row run with no idling on either side
      stall_on = !(r >= 18 && r < 21);
      n = rows[r].text.len();
      if (rows[r].raw[8])
        send(rows[r].raw[7:0], rows[r].eos && n == 0, rows[r].typed && n == 0,
             rows[r].kind, rows[r].err, rows[r].bad);
      for (int i = 0; i < n; i++)
        send(rows[r].text[i], rows[r].eos && i == n - 1, rows[r].typed && i == n - 1,
             rows[r].kind, rows[r].err, rows[r].bad);
    end
    stall_on = 1'b1;

    while (source_q.size() < RANDOM_BYTES) begin
      case ($urandom_range(13))
        0:  frag = {kw_names[$urandom_range(28)], " "};
        1:  frag = {random_word($urandom_range(1, 12)), " "};
        2:  frag = random_word($urandom_range(1, 10));
        3: begin
          frag = random_digits($urandom_range(1, 4));
          case ($urandom_range(2))
            0: frag = {frag, ".", random_digits($urandom_range(1, 3))};
            1: frag = {frag, "."};
            default: ;
          endcase
        end
        4:  frag = {"\"", random_text($urandom_range(0, 8), "\""), "\""};
        5:  frag = {"'", random_text($urandom_range(0, 2), "'"), "'"};
        6, 7: frag = op_names[$urandom_range(44)];
        8: begin
          case ($urandom_range(3))
            0: frag = " ";
            1: frag = "\t";
            2: frag = "\r";
            default: frag = "\n";
          endcase
        end
        9:  frag = {"#", random_text($urandom_range(0, 6), 8'h0A), "\n"};
        10: frag = {"//", random_text($urandom_range(0, 6), 8'h0A), "\n"};
        11: frag = {"/*", random_text($urandom_range(0, 6), "/"), "*/"};
        default: frag = "";
      endcase
      foreach (frag[i]) source_q.push_back({1'b0, frag[i]});
      if ($urandom_range(29) == 0) source_q.push_back({1'b0, 8'($urandom_range(255))});
      if ($urandom_range(11) == 0 && source_q.size() > 0)
        source_q[source_q.size() - 1][8] = 1'b1;
    end
    source_q[source_q.size() - 1][8] = 1'b1;

    foreach (source_q[i]) begin
      send_plain(source_q[i]);
    end
    in_ch.valid <= 1'b0;

    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("%0d source bytes scanned, %0d tokens checked, %0d mismatches",
             bytes_sent, tokens_seen, mismatches);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= !(stall_on && $urandom_range(99) < 28);
  end

  always @(posedge clk) begin
    token_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      tokens_seen++;
      if (expected_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected token kind %0d", out_ch.token_kind);
      end else begin
        want = expected_tokens.pop_front();
        if (out_ch.token_kind !== want.kind || out_ch.error_code !== want.err ||
            out_ch.bad_byte !== want.bad || out_ch.line_number !== want.line ||
            out_ch.first_column !== want.col || out_ch.start_offset !== want.off ||
            out_ch.token_length !== want.len || out_ch.last_result !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("token mismatch: exp kind %0d err %0d bad %h line %0d col %0d off %0d len %0d last %0d, got kind %0d err %0d bad %h line %0d col %0d off %0d len %0d last %0d",
                     want.kind, want.err, want.bad, want.line, want.col, want.off,
                     want.len, want.last, out_ch.token_kind, out_ch.error_code,
                     out_ch.bad_byte, out_ch.line_number, out_ch.first_column,
                     out_ch.start_offset, out_ch.token_length, out_ch.last_result);
        end
      end
    end
  end

  // watchdog on transfers
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

### files.f
rtl/tsc_pkg.sv
rtl/tsc_if.sv
rtl/c_subset_token_scanner.sv
bench/c_subset_token_scanner_test.sv
